### rtl/hdtmc_pkg.sv
// Shared constants, register indexes and types for the hard-disc trial-move checker.
// No dependencies; every rtl file refers to this package by scoped names.
package hdtmc_pkg;

  // Default store depth
  localparam int MAX_DISCS_DEF = 256;

  // Field widths
  localparam int COORD_W    = 21;  // signed Q4.16 coordinate
  localparam int IDX_W      = 8;   // disc index field
  localparam int DIST_W     = 44;  // Q12.32 squared distance
  localparam int CNT_W      = 32;  // reject counter
  localparam int DISCS_W    = 9;   // discs_in_use register
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 44;

  // Register reset values
  localparam logic [DISCS_W-1:0] DISCS_RST   = 9'd256;
  localparam logic [DIST_W-1:0]  CONTACT_RST = 44'd21474836;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DISCS_IN_USE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CONTACT_DIST_SQ = 2'd1;

  // Item operations
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_MOVE = 1'b1;

  typedef logic signed [COORD_W-1:0] coord_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_CLEAR,   // zeroing sweep after reset
    ST_IDLE,    // waiting for an item
    ST_SELF,    // moved disc's centre returned, trial position formed
    ST_SCAN,    // one read of the store per cycle
    ST_DRAIN,   // distance pipeline empties
    ST_WB,      // write back or count the reject
    ST_OUT      // hand the result to the output register
  } state_t;

endpackage

### rtl/hard_disc_trial_move_checker_unit.sv
// Top level of the hard-disc trial-move checker: centre store, overlap scan and result register.
// Depends on hdtmc_pkg.
//
//  channel  | handshake             | payload
//  ---------+-----------------------+------------------------------------------------
//  cfg      | cfg_valid / cfg_ready | cfg_index, cfg_data
//  in       | in_valid / in_ready   | in_op, in_disc_index, in_x_value, in_y_value
//  out      | out_valid / out_ready | out_accepted, out_new_x, out_new_y,
//           |                       | out_rejects_so_far
//
// A load, or an index outside the store, goes from idle through ST_OUT to the output register;
// a move goes through ST_SELF, ST_SCAN, ST_DRAIN, ST_WB and ST_OUT. The scan reads the centre
// store once per disc in use (clamped to MAX_DISCS) through a two-stage square-and-compare pipe.
// A new item is taken only once the last has been handed over and the sequencer is idle again.
// After reset a zeroing sweep over every store address runs; no item is taken until it ends.
// A result waiting in the output register does not block the next input transfer; the
// block only stalls at its final hand-over while the output register is still full.
module hard_disc_trial_move_checker_unit #(
  parameter int MAX_DISCS = hdtmc_pkg::MAX_DISCS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [hdtmc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [hdtmc_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 in_op,
  input  logic [hdtmc_pkg::IDX_W-1:0]          in_disc_index,
  input  logic signed [hdtmc_pkg::COORD_W-1:0] in_x_value,
  input  logic signed [hdtmc_pkg::COORD_W-1:0] in_y_value,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic                                 out_accepted,
  output logic signed [hdtmc_pkg::COORD_W-1:0] out_new_x,
  output logic signed [hdtmc_pkg::COORD_W-1:0] out_new_y,
  output logic [hdtmc_pkg::CNT_W-1:0]          out_rejects_so_far
);

  localparam int COORD_W = hdtmc_pkg::COORD_W;
  localparam int DIST_W  = hdtmc_pkg::DIST_W;
  localparam int CNT_W   = hdtmc_pkg::CNT_W;
  localparam int AW      = $clog2(MAX_DISCS);
  localparam int NW_RAW  = $clog2(MAX_DISCS + 1);
  localparam int NW      = (NW_RAW > hdtmc_pkg::DISCS_W) ? NW_RAW : hdtmc_pkg::DISCS_W;
  localparam int MW      = 2 * COORD_W;   // store word: {x, y}
  localparam int DW      = COORD_W + 1;   // coordinate difference
  localparam logic [NW-1:0] MAX_N     = NW'(MAX_DISCS);
  localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_DISCS - 1);

  hdtmc_pkg::state_t state_r, state_nxt;

  // Centre store
  logic [MW-1:0] mem [MAX_DISCS];
  logic [MW-1:0] rdata_r;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [AW-1:0] mem_raddr;
  logic [MW-1:0] mem_wdata;

  logic [AW-1:0] clr_ptr_r;

  // Configuration
  logic [hdtmc_pkg::DISCS_W-1:0] discs_r;
  logic [DIST_W-1:0]             contact_r;

  // Item context
  logic [AW-1:0]     self_addr_r;
  hdtmc_pkg::coord_t step_x_r, step_y_r;
  hdtmc_pkg::coord_t self_x_r, self_y_r;
  hdtmc_pkg::coord_t tx_r, ty_r;

  // Scan pipeline
  logic [NW-1:0]     scan_ptr_r;
  logic              issue;
  logic              rd_valid_r;
  logic [AW-1:0]     rd_tag_r;
  logic              s2_valid_r;
  logic [DIST_W-1:0] sqx_r, sqy_r;
  logic              overlap_r;

  logic [CNT_W-1:0] rej_cnt_r;

  // Result staging and output register
  logic              res_acc_r;
  hdtmc_pkg::coord_t res_x_r, res_y_r;
  logic              out_valid_r;
  logic              out_acc_r;
  hdtmc_pkg::coord_t out_x_r, out_y_r;
  logic [CNT_W-1:0]  out_rej_r;

  // Combinational helpers
  logic [NW-1:0]        n_eff;
  logic [NW-1:0]        idx_ext;
  logic                 idx_in_range;
  logic                 in_fire;
  logic                 out_free;
  hdtmc_pkg::coord_t    cx, cy;
  logic signed [DW-1:0] sum_x, sum_y;
  hdtmc_pkg::coord_t    tx_sat, ty_sat;
  logic signed [DW-1:0] dx, dy;
  logic signed [2*DW-1:0] px, py;
  logic [DIST_W-1:0]    dsum;
  logic                 hit;

  assign cfg_ready          = 1'b1;
  assign out_valid          = out_valid_r;
  assign out_accepted       = out_acc_r;
  assign out_new_x          = out_x_r;
  assign out_new_y          = out_y_r;
  assign out_rejects_so_far = out_rej_r;

  // Discs taking part, clamped to the store depth
  assign n_eff = (NW'(discs_r) > MAX_N) ? MAX_N : NW'(discs_r);

  assign idx_ext      = NW'(in_disc_index);
  assign idx_in_range = (idx_ext < MAX_N);
  assign in_fire      = in_valid && in_ready;
  assign out_free     = !out_valid_r || out_ready;

  // Trial position: saturating add of the step to the stored centre
  assign cx    = rdata_r[MW-1:COORD_W];
  assign cy    = rdata_r[COORD_W-1:0];
  assign sum_x = DW'(cx) + DW'(step_x_r);
  assign sum_y = DW'(cy) + DW'(step_y_r);

  always_comb begin
    if (sum_x[DW-1] != sum_x[DW-2]) begin
      tx_sat = sum_x[DW-1] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
    end else begin
      tx_sat = sum_x[COORD_W-1:0];
    end
    if (sum_y[DW-1] != sum_y[DW-2]) begin
      ty_sat = sum_y[DW-1] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
    end else begin
      ty_sat = sum_y[COORD_W-1:0];
    end
  end

  // Stage A: differences and squares against the disc just read
  assign dx = DW'(tx_r) - DW'(cx);
  assign dy = DW'(ty_r) - DW'(cy);
  assign px = dx * dx;
  assign py = dy * dy;

  // Stage B: sum and contact compare (sum stays below 2^43)
  assign dsum = sqx_r + sqy_r;
  assign hit  = (dsum < contact_r);

  // Sequencer: next state, store port and handshake
  always_comb begin
    state_nxt = state_r;
    mem_we    = 1'b0;
    mem_waddr = self_addr_r;
    mem_wdata = {tx_r, ty_r};
    mem_raddr = AW'(scan_ptr_r);
    in_ready  = 1'b0;
    issue     = 1'b0;
    case (state_r)
      hdtmc_pkg::ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_ptr_r;
        mem_wdata = '0;
        if (clr_ptr_r == LAST_ADDR) state_nxt = hdtmc_pkg::ST_IDLE;
      end
      hdtmc_pkg::ST_IDLE: begin
        in_ready  = 1'b1;
        mem_raddr = AW'(idx_ext);
        if (in_fire) begin
          if (idx_in_range && in_op == hdtmc_pkg::OP_MOVE) begin
            state_nxt = hdtmc_pkg::ST_SELF;
          end else begin
            state_nxt = hdtmc_pkg::ST_OUT;
            if (idx_in_range) begin
              mem_we    = 1'b1;
              mem_waddr = AW'(idx_ext);
              mem_wdata = {in_x_value, in_y_value};
            end
          end
        end
      end
      hdtmc_pkg::ST_SELF: begin
        state_nxt = hdtmc_pkg::ST_SCAN;
      end
      hdtmc_pkg::ST_SCAN: begin
        if (scan_ptr_r < n_eff) begin
          issue = 1'b1;
        end else begin
          state_nxt = hdtmc_pkg::ST_DRAIN;
        end
      end
      hdtmc_pkg::ST_DRAIN: begin
        if (!rd_valid_r && !s2_valid_r) state_nxt = hdtmc_pkg::ST_WB;
      end
      hdtmc_pkg::ST_WB: begin
        mem_we    = !overlap_r;
        state_nxt = hdtmc_pkg::ST_OUT;
      end
      hdtmc_pkg::ST_OUT: begin
        if (out_free) state_nxt = hdtmc_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = hdtmc_pkg::ST_IDLE;
      end
    endcase
  end

  // Centre store: one write, one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_r <= mem[mem_raddr];
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= hdtmc_pkg::ST_CLEAR;
      clr_ptr_r   <= '0;
      discs_r     <= hdtmc_pkg::DISCS_RST;
      contact_r   <= hdtmc_pkg::CONTACT_RST;
      scan_ptr_r  <= '0;
      rd_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      overlap_r   <= 1'b0;
      rej_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;

      if (state_r == hdtmc_pkg::ST_CLEAR) clr_ptr_r <= clr_ptr_r + 1'b1;

      // Register writes; unknown indexes are dropped
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          hdtmc_pkg::REG_DISCS_IN_USE:    discs_r   <= cfg_data[hdtmc_pkg::DISCS_W-1:0];
          hdtmc_pkg::REG_CONTACT_DIST_SQ: contact_r <= cfg_data[DIST_W-1:0];
          default: ;
        endcase
      end

      // Scan pointer and pipeline valids; the moved disc is dropped at stage A
      if (in_fire) begin
        scan_ptr_r <= '0;
      end else if (issue) begin
        scan_ptr_r <= scan_ptr_r + 1'b1;
      end
      rd_valid_r <= issue;
      s2_valid_r <= rd_valid_r && (rd_tag_r != self_addr_r);

      // Sticky overlap flag
      if (in_fire) begin
        overlap_r <= 1'b0;
      end else if (s2_valid_r && hit) begin
        overlap_r <= 1'b1;
      end

      // Saturating reject count
      if (state_r == hdtmc_pkg::ST_WB && overlap_r && rej_cnt_r != {CNT_W{1'b1}}) begin
        rej_cnt_r <= rej_cnt_r + 1'b1;
      end

      // Output register
      if (state_r == hdtmc_pkg::ST_OUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    rd_tag_r <= AW'(scan_ptr_r);
    sqx_r    <= DIST_W'($unsigned(px));
    sqy_r    <= DIST_W'($unsigned(py));

    if (in_fire) begin
      self_addr_r <= AW'(idx_ext);
      step_x_r    <= in_x_value;
      step_y_r    <= in_y_value;
      res_acc_r   <= idx_in_range;
      res_x_r     <= idx_in_range ? in_x_value : '0;
      res_y_r     <= idx_in_range ? in_y_value : '0;
    end

    if (state_r == hdtmc_pkg::ST_SELF) begin
      self_x_r <= cx;
      self_y_r <= cy;
      tx_r     <= tx_sat;
      ty_r     <= ty_sat;
    end

    if (state_r == hdtmc_pkg::ST_WB) begin
      res_acc_r <= !overlap_r;
      res_x_r   <= overlap_r ? self_x_r : tx_r;
      res_y_r   <= overlap_r ? self_y_r : ty_r;
    end

    if (state_r == hdtmc_pkg::ST_OUT && out_free) begin
      out_acc_r <= res_acc_r;
      out_x_r   <= res_x_r;
      out_y_r   <= res_y_r;
      out_rej_r <= rej_cnt_r;
    end
  end

`ifndef NO_ASSERTIONS
  // Reject count never goes down outside reset
  a_rej_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n |=> (rej_cnt_r >= $past(rej_cnt_r)))
    else $error("reject counter decreased");

  // Reject count only moves at write-back
  a_rej_only_wb: assert property (@(posedge clk) disable iff (!rst_n)
    (rst_n && state_r != hdtmc_pkg::ST_WB) |=> $stable(rej_cnt_r))
    else $error("reject counter changed outside write-back");

  // Scan pipeline is empty when the verdict is used
  a_drained_at_wb: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == hdtmc_pkg::ST_WB) |-> (!rd_valid_r && !s2_valid_r))
    else $error("write-back with scan still in flight");

  // A transfer always leaves the idle state
  a_fire_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r != hdtmc_pkg::ST_IDLE))
    else $error("item transfer not taken up by the sequencer");
`endif

endmodule

### verif/hard_disc_trial_move_checker_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for hard_disc_trial_move_checker_unit: loads, trial moves, register writes.
// Depends on hdtmc_pkg and the unit's RTL; keeps its own copy of the centre store to predict results.
module hard_disc_trial_move_checker_unit_tb;

  localparam int COORD_W    = hdtmc_pkg::COORD_W;
  localparam int IDX_W      = hdtmc_pkg::IDX_W;
  localparam int CNT_W      = hdtmc_pkg::CNT_W;
  localparam int DISCS_W    = hdtmc_pkg::DISCS_W;
  localparam int DIST_W     = hdtmc_pkg::DIST_W;
  localparam int CFG_IDX_W  = hdtmc_pkg::CFG_IDX_W;
  localparam int CFG_DATA_W = hdtmc_pkg::CFG_DATA_W;
  typedef hdtmc_pkg::coord_t coord_t;

  localparam int NUM_DISCS = hdtmc_pkg::MAX_DISCS_DEF;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;  // no register behind this index
  localparam int LATTICE_STEP = 16384;                 // 0.25 in Q4.16
  localparam coord_t COORD_HI = {1'b0, {(COORD_W-1){1'b1}}};
  localparam coord_t COORD_LO = {1'b1, {(COORD_W-1){1'b0}}};

  typedef struct packed {
    logic             op;
    logic [IDX_W-1:0] disc;
    coord_t           x;
    coord_t           y;
  } disc_item_t;

  typedef struct packed {
    logic             accepted;
    coord_t           new_x;
    coord_t           new_y;
    logic [CNT_W-1:0] rejects;
  } disc_result_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_valid;
  logic                  in_ready;
  logic                  in_op;
  logic [IDX_W-1:0]      in_disc_index;
  coord_t                in_x_value;
  coord_t                in_y_value;
  logic                  out_valid;
  logic                  out_ready;
  logic                  out_accepted;
  coord_t                out_new_x;
  coord_t                out_new_y;
  logic [CNT_W-1:0]      out_rejects_so_far;

  hard_disc_trial_move_checker_unit DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_op              (in_op),
    .in_disc_index      (in_disc_index),
    .in_x_value         (in_x_value),
    .in_y_value         (in_y_value),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_accepted       (out_accepted),
    .out_new_x          (out_new_x),
    .out_new_y          (out_new_y),
    .out_rejects_so_far (out_rejects_so_far)
  );

  // Predicted centre store, registers and reject count
  coord_t              centre_x_copy [NUM_DISCS];
  coord_t              centre_y_copy [NUM_DISCS];
  logic [CNT_W-1:0]    reject_count_copy;
  logic [DISCS_W-1:0]  discs_in_use_copy;
  logic [DIST_W-1:0]   contact_sq_copy;

  disc_item_t   pending_items[$];
  disc_result_t expected_results[$];
  int           items_issued;
  int           results_seen;
  int           mismatches;
  int           send_idle_pct;
  int           recv_stall_pct;
  logic         in_sent;

  // Clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Every input known from time zero; reset held low from time zero, then released on a falling edge
  initial begin
    rst_n          = 1'b0;
    cfg_valid      = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    in_valid       = 1'b0;
    in_op          = hdtmc_pkg::OP_LOAD;
    in_disc_index  = '0;
    in_x_value     = '0;
    in_y_value     = '0;
    out_ready      = 1'b0;
    in_sent        = 1'b0;
    items_issued   = 0;
    results_seen   = 0;
    mismatches     = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (7) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;
  end

  function automatic coord_t clamp_coord(longint v);
    if (v > longint'(COORD_HI)) return COORD_HI;
    if (v < longint'(COORD_LO)) return COORD_LO;
    return coord_t'(v);
  endfunction

  // True when the trial centre sits closer than contact to any other disc in use
  function automatic logic touches_neighbour(longint tx, longint ty, int self);
    int     n;
    longint dx;
    longint dy;
    n = (int'(discs_in_use_copy) > NUM_DISCS) ? NUM_DISCS : int'(discs_in_use_copy);
    for (int i = 0; i < n; i++) begin
      if (i == self) continue;
      dx = tx - longint'(centre_x_copy[i]);
      dy = ty - longint'(centre_y_copy[i]);
      if (dx * dx + dy * dy < longint'(contact_sq_copy)) return 1'b1;
    end
    return 1'b0;
  endfunction

  // Applies one item to the store copy and returns the result it should give
  function automatic disc_result_t settle_disc_item(disc_item_t it);
    disc_result_t r;
    coord_t       tx;
    coord_t       ty;
    r = '0;
    if (int'(it.disc) < NUM_DISCS) begin
      if (it.op == hdtmc_pkg::OP_LOAD) begin
        centre_x_copy[it.disc] = it.x;
        centre_y_copy[it.disc] = it.y;
        r.accepted = 1'b1;
      end else begin
        tx = clamp_coord(longint'(centre_x_copy[it.disc]) + longint'(it.x));
        ty = clamp_coord(longint'(centre_y_copy[it.disc]) + longint'(it.y));
        if (touches_neighbour(tx, ty, int'(it.disc))) begin
          if (reject_count_copy != '1) reject_count_copy++;
        end else begin
          centre_x_copy[it.disc] = tx;
          centre_y_copy[it.disc] = ty;
          r.accepted = 1'b1;
        end
      end
      r.new_x = centre_x_copy[it.disc];
      r.new_y = centre_y_copy[it.disc];
    end
    r.rejects = reject_count_copy;
    return r;
  endfunction

  task automatic report_mismatch(string what, disc_result_t want, disc_result_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("%t %s: expected acc=%0b x=%0d y=%0d rej=%0d, got acc=%0b x=%0d y=%0d rej=%0d",
               $realtime, what, want.accepted, want.new_x, want.new_y, want.rejects,
               got.accepted, got.new_x, got.new_y, got.rejects);
  endtask

  // Register writes, result checks and prediction, all on the rising edge
  always @(posedge clk) begin
    disc_result_t want;
    disc_result_t got;
    in_sent <= in_valid && in_ready;
    if (!rst_n) begin
      for (int i = 0; i < NUM_DISCS; i++) begin
        centre_x_copy[i] = '0;
        centre_y_copy[i] = '0;
      end
      reject_count_copy = '0;
      discs_in_use_copy = hdtmc_pkg::DISCS_RST;
      contact_sq_copy   = hdtmc_pkg::CONTACT_RST;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          hdtmc_pkg::REG_DISCS_IN_USE:    discs_in_use_copy = cfg_data[DISCS_W-1:0];
          hdtmc_pkg::REG_CONTACT_DIST_SQ: contact_sq_copy = cfg_data[DIST_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        got = {out_accepted, out_new_x, out_new_y, out_rejects_so_far};
        if (expected_results.size() == 0) begin
          report_mismatch("result with nothing outstanding", '0, got);
        end else begin
          want = expected_results.pop_front();
          results_seen++;
          if (got.accepted !== want.accepted || got.new_x !== want.new_x ||
              got.new_y !== want.new_y || got.rejects !== want.rejects)
            report_mismatch("result mismatch", want, got);
        end
      end
      if (in_valid && in_ready)
        expected_results.push_back(settle_disc_item({in_op, in_disc_index,
                                                     in_x_value, in_y_value}));
    end
  end

  // Sender and receiver, both driven on the falling edge
  always @(negedge clk) begin
    disc_item_t nxt;
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_sent) begin
      if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt = pending_items.pop_front();
        in_valid      <= 1'b1;
        in_op         <= nxt.op;
        in_disc_index <= nxt.disc;
        in_x_value    <= nxt.x;
        in_y_value    <= nxt.y;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  task automatic push_item(logic op, int disc, coord_t x, coord_t y);
    pending_items.push_back({op, IDX_W'(disc), x, y});
    items_issued++;
  endtask

  // Every issued item has had its result
  task automatic wait_drained();
    do @(negedge clk); while (results_seen != items_issued);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk) cfg_valid <= 1'b0;
  endtask

  // Square lattice, 16 discs a row, from -8 to +7 lattice steps on each axis
  task automatic load_lattice(int n);
    for (int i = 0; i < n; i++)
      push_item(hdtmc_pkg::OP_LOAD, i, coord_t'(((i % 16) - 8) * LATTICE_STEP),
                coord_t'(((i / 16) - 8) * LATTICE_STEP));
  endtask

  // Mostly small moves among the discs in use, some loads, some full-range noise
  task automatic random_items(int n, int count);
    int roll;
    int disc;
    for (int k = 0; k < count; k++) begin
      roll = $urandom_range(99);
      disc = ($urandom_range(9) == 0) ? $urandom_range(NUM_DISCS - 1) : $urandom_range(n - 1);
      if (roll < 70)
        push_item(hdtmc_pkg::OP_MOVE, disc,
                  coord_t'(int'($urandom_range(LATTICE_STEP)) - LATTICE_STEP / 2),
                  coord_t'(int'($urandom_range(LATTICE_STEP)) - LATTICE_STEP / 2));
      else if (roll < 85)
        push_item(hdtmc_pkg::OP_LOAD, disc, coord_t'($urandom()), coord_t'($urandom()));
      else
        push_item(hdtmc_pkg::OP_MOVE, $urandom_range(NUM_DISCS - 1), coord_t'($urandom()),
                  coord_t'($urandom()));
    end
  endtask

  // Stimulus
  initial begin
    int     n;
    longint reach;
    @(posedge rst_n);

    // Directed: saturation at both ends, overlap at reset, register extremes
    push_item(hdtmc_pkg::OP_MOVE, 0, coord_t'(100), coord_t'(-100));
    push_item(hdtmc_pkg::OP_LOAD, 5, COORD_HI, COORD_HI);
    push_item(hdtmc_pkg::OP_MOVE, 5, COORD_HI, COORD_HI);
    push_item(hdtmc_pkg::OP_LOAD, 6, COORD_LO, COORD_LO);
    push_item(hdtmc_pkg::OP_MOVE, 6, COORD_LO, COORD_LO);
    push_item(hdtmc_pkg::OP_LOAD, 7, COORD_LO, COORD_HI);
    push_item(hdtmc_pkg::OP_MOVE, 7, COORD_HI, COORD_LO);
    push_item(hdtmc_pkg::OP_LOAD, 255, COORD_HI, COORD_LO);
    wait_drained();
    // no disc in use: every move clears
    write_reg(hdtmc_pkg::REG_DISCS_IN_USE, CFG_DATA_W'(0));
    push_item(hdtmc_pkg::OP_MOVE, 1, coord_t'(5), coord_t'(5));
    wait_drained();
    // above the store depth: clamped
    write_reg(hdtmc_pkg::REG_DISCS_IN_USE, CFG_DATA_W'(300));
    push_item(hdtmc_pkg::OP_MOVE, 2, coord_t'(0), coord_t'(0));
    wait_drained();
    write_reg(hdtmc_pkg::REG_CONTACT_DIST_SQ, '0);
    push_item(hdtmc_pkg::OP_MOVE, 3, coord_t'(0), coord_t'(0));
    wait_drained();
    write_reg(hdtmc_pkg::REG_CONTACT_DIST_SQ, '1);
    push_item(hdtmc_pkg::OP_MOVE, 5, COORD_LO, coord_t'(0));
    wait_drained();
    // write to an unused index changes nothing
    write_reg(REG_SPARE, CFG_DATA_W'(44'h5A5_A5A5_A5A5));
    push_item(hdtmc_pkg::OP_MOVE, 4, coord_t'(0), coord_t'(0));
    wait_drained();
    // one disc in use: a disc outside the set is checked against it
    write_reg(hdtmc_pkg::REG_DISCS_IN_USE, CFG_DATA_W'(1));
    write_reg(hdtmc_pkg::REG_CONTACT_DIST_SQ, CFG_DATA_W'(hdtmc_pkg::CONTACT_RST));
    push_item(hdtmc_pkg::OP_MOVE, 200, coord_t'(0), coord_t'(0));
    push_item(hdtmc_pkg::OP_MOVE, 200, coord_t'(LATTICE_STEP), coord_t'(LATTICE_STEP));
    push_item(hdtmc_pkg::OP_MOVE, 0, coord_t'(-300000), coord_t'(700000));
    push_item(hdtmc_pkg::OP_LOAD, 0, coord_t'(0), coord_t'(0));

    // Random sets: no idling, sender idle, receiver stalling, both
    for (int s = 0; s < 8; s++) begin
      wait_drained();
      send_idle_pct  = (s / 2 == 1) ? 73 : (s / 2 == 3) ? 27 : 0;
      recv_stall_pct = (s / 2 == 2) ? 73 : (s / 2 == 3) ? 27 : 0;
      n = (s == 2) ? 1 : (s == 5) ? NUM_DISCS : $urandom_range(2, 16);
      reach = longint'($urandom_range(LATTICE_STEP / 2, LATTICE_STEP));
      write_reg(hdtmc_pkg::REG_DISCS_IN_USE, CFG_DATA_W'(n));
      write_reg(hdtmc_pkg::REG_CONTACT_DIST_SQ, CFG_DATA_W'(reach * reach));
      load_lattice(n);
      random_items(n, 12);
    end

    wait_drained();
    repeat (NUM_DISCS + 16) @(negedge clk);
    if (mismatches == 0 && expected_results.size() == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

### sim.f
rtl/hdtmc_pkg.sv
rtl/hard_disc_trial_move_checker_unit.sv
verif/hard_disc_trial_move_checker_unit_tb.sv
